[design/rsgt_pkg.sv]
`default_nettype none

package rsgt_pkg;

  // field widths
  localparam int ADDR_W = 32;
  localparam int HW_W   = 16;
  localparam int SLOT_W = 3;
  localparam int OUTC_W = 2;
  localparam int BYTES_W = 6;

  // default table depth
  localparam int DEF_SLOTS = 8;

  // opcodes
  localparam logic OP_NOTE  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_NONE     = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_RECORDED = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_CONSUMED = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_STALE    = 2'd3;

  // thumb instruction patterns
  localparam logic [HW_W-1:0] BLX_MASK  = 16'hff87;
  localparam logic [HW_W-1:0] BLX_MATCH = 16'h4780;
  localparam logic [HW_W-1:0] POP_MASK  = 16'hfe00;
  localparam logic [HW_W-1:0] POP_MATCH = 16'hbc00;
  localparam logic [HW_W-1:0] POP_PC    = 16'h0100;
  localparam logic [HW_W-1:0] POP_REGS  = 16'h00ff;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] stack_ptr;
    logic [ADDR_W-1:0] link_reg;
    logic [HW_W-1:0]   prev_halfword;
    logic [HW_W-1:0]   cur_halfword;
    logic              prev_readable;
    logic              cur_readable;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  // decoded facts about the site of one request
  typedef struct packed {
    logic               guarded;
    logic               pop_ok;
    logic [BYTES_W-1:0] pop_size;
  } site_info_t;

endpackage

`default_nettype wire

[design/rsgt_decode.sv]
`default_nettype none

module rsgt_decode (
  input  wire rsgt_pkg::in_item_t   item,
  output rsgt_pkg::site_info_t      info
);

  logic blx;
  logic pop_pc;
  logic site_ok;
  logic [3:0] nregs;

  // instruction pattern match
  assign blx = (item.prev_halfword & rsgt_pkg::BLX_MASK) == rsgt_pkg::BLX_MATCH;
  assign pop_pc = ((item.cur_halfword & rsgt_pkg::POP_MASK) == rsgt_pkg::POP_MATCH) &&
                  ((item.cur_halfword & rsgt_pkg::POP_PC) != '0);
  // site is address with thumb bit cleared, must be at least 2
  assign site_ok = |item.address[rsgt_pkg::ADDR_W-1:1];

  // count low registers in the pop list
  always_comb begin
    nregs = '0;
    for (int b = 0; b < 8; b++) begin
      nregs = nregs + 4'(item.cur_halfword[b]);
    end
  end

  always_comb begin
    info.guarded  = site_ok && item.prev_readable && item.cur_readable && blx && pop_pc;
    info.pop_ok   = item.cur_readable && pop_pc;
    info.pop_size = {(rsgt_pkg::BYTES_W-4)'(0), nregs} + rsgt_pkg::BYTES_W'(1);
    info.pop_size = {info.pop_size[rsgt_pkg::BYTES_W-3:0], 2'b00};
  end

endmodule

`default_nettype wire

[design/return_site_guard_table.sv]
// return site guard table
//
// Input channel in_valid / in_stall / in_item carries one request: a note
// (opcode 0) records a pending entry for a guarded return site, a check
// (opcode 1) consumes a matching pending entry or reports a stale return.
// Every request gives exactly one result on out_valid / out_stall / out_item.
//
// Entry site and saved SP live in a synchronous memory with one read port and
// one write port; the request scans all SLOTS entries one per cycle, then
// updates the table. A request goes through the scan, a drain state and a
// done state, where the result register is loaded once it is free or the
// receiver does not stall. One request is in work at a time; the next is
// taken the cycle after the result is loaded.
//
// Reset clears all pending and in-use bits and the replacement pointer, so
// the table is empty at once with no clearing pass. While the receiver stalls,
// the result is held and a finished request waits before writing the table.
`default_nettype none

module return_site_guard_table #(
  parameter int SLOTS = rsgt_pkg::DEF_SLOTS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire rsgt_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire                    out_stall,
  output rsgt_pkg::out_item_t    out_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam int AW = rsgt_pkg::ADDR_W;
  localparam int EW = 2 * AW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  rsgt_pkg::in_item_t  req_r;
  rsgt_pkg::site_info_t info;
  rsgt_pkg::out_item_t out_r, res;
  logic                out_valid_r;

  logic [IW-1:0] cnt_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] ptr_r;
  logic [SLOTS-1:0] pend_r;
  logic [SLOTS-1:0] used_r;

  // table memory: {site, saved sp}
  logic [EW-1:0] mem_r [SLOTS];
  logic [EW-1:0] rdata_r;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  // scan results
  logic          match_fnd_r;
  logic [IW-1:0] match_idx_r;
  logic          free_fnd_r;
  logic [IW-1:0] free_idx_r;
  logic          idx_fnd_r;
  logic [IW-1:0] idx_r;
  logic          idx_pend_r;
  logic          idx_spm_r;

  logic [AW-1:0] site;
  logic          site_eq;
  logic          sp_eq;
  logic          e_pend;
  logic [AW:0]   sp_after;
  logic          lr_ok;
  logic          accept;
  logic          can_load;
  logic          commit;
  logic          set_pend;
  logic          clr_pend;
  logic          adv_ptr;
  logic [IW-1:0] upd_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_load = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_DONE) && can_load;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  rsgt_decode u_decode (
    .item (req_r),
    .info (info)
  );

  assign site = {req_r.address[AW-1:1], 1'b0};

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (can_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_item;
    cmp_idx_r <= cnt_r;
  end

  // memory read and write
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[cnt_r];
    if (we) mem_r[waddr] <= wdata;
  end

  // compare the entry read back
  assign e_pend  = pend_r[cmp_idx_r];
  assign site_eq = used_r[cmp_idx_r] && (rdata_r[EW-1:AW] == site);
  assign sp_eq   = (rdata_r[AW-1:0] == req_r.stack_ptr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
      idx_fnd_r   <= 1'b0;
    end else if (accept) begin
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
      idx_fnd_r   <= 1'b0;
    end else if (cmp_vld_r) begin
      if (!match_fnd_r && e_pend && site_eq && sp_eq) begin
        match_fnd_r <= 1'b1;
      end
      if (!free_fnd_r && !e_pend && (!used_r[cmp_idx_r] || site_eq)) begin
        free_fnd_r <= 1'b1;
      end
      if (!idx_fnd_r && site_eq) begin
        idx_fnd_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (!match_fnd_r) match_idx_r <= cmp_idx_r;
      if (!free_fnd_r) free_idx_r <= cmp_idx_r;
      if (!idx_fnd_r) begin
        idx_r      <= cmp_idx_r;
        idx_pend_r <= e_pend;
        idx_spm_r  <= sp_eq;
      end
    end
  end

  // decide the outcome and the table update
  assign sp_after = {1'b0, req_r.stack_ptr} + (AW+1)'(info.pop_size);
  assign lr_ok = req_r.link_reg[0] && (req_r.link_reg[AW-1:1] == req_r.address[AW-1:1]);

  always_comb begin
    res.outcome = rsgt_pkg::OUTC_NONE;
    res.slot    = '0;
    set_pend    = 1'b0;
    clr_pend    = 1'b0;
    adv_ptr     = 1'b0;
    upd_idx     = '0;
    wdata       = {site, req_r.stack_ptr};
    if (req_r.opcode == rsgt_pkg::OP_NOTE) begin
      if (req_r.address[0] && info.guarded && !match_fnd_r) begin
        set_pend    = 1'b1;
        res.outcome = rsgt_pkg::OUTC_RECORDED;
        if (free_fnd_r) begin
          upd_idx = free_idx_r;
        end else begin
          upd_idx = ptr_r;
          adv_ptr = 1'b1;
        end
        res.slot = rsgt_pkg::SLOT_W'(upd_idx);
      end
    end else if ((site != '0) && idx_fnd_r) begin
      if (match_fnd_r && info.pop_ok && !sp_after[AW]) begin
        clr_pend    = 1'b1;
        upd_idx     = match_idx_r;
        wdata       = {site, sp_after[AW-1:0]};
        res.outcome = rsgt_pkg::OUTC_CONSUMED;
        res.slot    = rsgt_pkg::SLOT_W'(match_idx_r);
      end else if (lr_ok && !idx_pend_r && idx_spm_r && info.guarded) begin
        res.outcome = rsgt_pkg::OUTC_STALE;
        res.slot    = rsgt_pkg::SLOT_W'(idx_r);
      end
    end
  end

  assign we    = commit && (set_pend || clr_pend);
  assign waddr = upd_idx;

  // entry flags and replacement pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      used_r <= '0;
      ptr_r  <= '0;
    end else if (commit) begin
      if (set_pend) begin
        pend_r[upd_idx] <= 1'b1;
        used_r[upd_idx] <= 1'b1;
      end
      if (clr_pend) pend_r[upd_idx] <= 1'b0;
      if (adv_ptr) ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + IW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_r <= res;
  end

endmodule

`default_nettype wire

[tb/return_site_guard_table_tb.sv]
`default_nettype none

module return_site_guard_table_tb;

  localparam int SLOTS           = rsgt_pkg::DEF_SLOTS;
  localparam int ADDR_W          = rsgt_pkg::ADDR_W;
  localparam int HW_W            = rsgt_pkg::HW_W;
  localparam int SLOT_W          = rsgt_pkg::SLOT_W;
  localparam int OUTC_W          = rsgt_pkg::OUTC_W;
  localparam int LATENCY         = SLOTS + 3;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int IDLE_LIMIT      = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SITE_POOL       = 10;
  localparam int SP_POOL         = 6;

  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  // thumb encodings for the directed rows
  localparam logic [HW_W-1:0] BLX_R3     = 16'h4798;
  localparam logic [HW_W-1:0] BLX_PC     = 16'h47f8;
  localparam logic [HW_W-1:0] BX_LR      = 16'h4770;
  localparam logic [HW_W-1:0] POP_R4_PC  = 16'hbd10;
  localparam logic [HW_W-1:0] POP_PC_ONE = 16'hbd00;
  localparam logic [HW_W-1:0] POP_ALL_PC = 16'hbdff;
  localparam logic [HW_W-1:0] POP_NO_PC  = 16'hbc10;

  localparam logic [ADDR_W-1:0] SITE_A = 32'h0000_1000;
  localparam logic [ADDR_W-1:0] SP_A   = 32'h2000_0100;
  localparam logic [ADDR_W-1:0] SP_B   = 32'h2000_0200;
  localparam logic [ADDR_W-1:0] ONES   = 32'hffff_ffff;

  typedef struct {
    rsgt_pkg::in_item_t  req;
    bit                  typed;
    rsgt_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rsgt_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsgt_pkg::out_item_t out_item;

  // mirror of the guard table
  logic [ADDR_W-1:0] tbl_site [SLOTS];
  logic [ADDR_W-1:0] tbl_sp [SLOTS];
  logic              tbl_pending [SLOTS];
  int                victim_ptr;

  rsgt_pkg::out_item_t outcome_queue[$];
  dir_row_t            directed_rows[$];
  logic [ADDR_W-1:0]   site_pool [SITE_POOL];
  logic [ADDR_W-1:0]   sp_pool [SP_POOL];

  int   errors = 0;
  int   outcome_seen [4];
  int   idle_cycles = 0;
  logic hold_req = 1'b0;
  logic no_idle = 1'b0;

  return_site_guard_table #(.SLOTS(SLOTS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pop that includes pc
  function automatic bit pop_with_pc(logic [HW_W-1:0] hw);
    return ((hw & rsgt_pkg::POP_MASK) == rsgt_pkg::POP_MATCH) &&
           ((hw & rsgt_pkg::POP_PC) != '0);
  endfunction

  // blx-register right before a pop with pc, both readable, site not below two
  function automatic bit site_guarded(rsgt_pkg::in_item_t req);
    return req.address[ADDR_W-1:1] != '0 && req.prev_readable && req.cur_readable &&
           (req.prev_halfword & rsgt_pkg::BLX_MASK) == rsgt_pkg::BLX_MATCH &&
           pop_with_pc(req.cur_halfword);
  endfunction

  // expected outcome of one request; updates the mirrored table
  function automatic rsgt_pkg::out_item_t guard_outcome(rsgt_pkg::in_item_t req);
    logic [ADDR_W-1:0]   site;
    logic [ADDR_W:0]     after;
    int                  hit;
    int                  first;
    int                  regs;
    rsgt_pkg::out_item_t res;
    site = {req.address[ADDR_W-1:1], 1'b0};
    res.outcome = rsgt_pkg::OUTC_NONE;
    res.slot = '0;
    if (req.opcode == rsgt_pkg::OP_NOTE) begin
      if (!req.address[0] || !site_guarded(req)) return res;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_pending[i] && tbl_site[i] == site && tbl_sp[i] == req.stack_ptr) return res;
      end
      // free or same-site slot first, else round robin
      hit = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && !tbl_pending[i] && (tbl_site[i] == '0 || tbl_site[i] == site)) hit = i;
      end
      if (hit < 0) begin
        hit = victim_ptr;
        victim_ptr = (victim_ptr + 1) % SLOTS;
      end
      tbl_site[hit] = site;
      tbl_sp[hit] = req.stack_ptr;
      tbl_pending[hit] = 1'b1;
      res.outcome = rsgt_pkg::OUTC_RECORDED;
      res.slot = SLOT_W'(hit);
      return res;
    end
    // check: site must be in the table
    first = -1;
    if (site != '0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (first < 0 && tbl_site[i] == site) first = i;
      end
    end
    if (first < 0) return res;
    // consume the first matching pending frame
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_pending[i] && tbl_site[i] == site && tbl_sp[i] == req.stack_ptr) begin
        if (req.cur_readable && pop_with_pc(req.cur_halfword)) begin
          regs = 0;
          for (int b = 0; b < 8; b++) regs += req.cur_halfword[b];
          after = req.stack_ptr + (regs + 1) * 4;
          if (!after[ADDR_W]) begin
            tbl_sp[i] = after[ADDR_W-1:0];
            tbl_pending[i] = 1'b0;
            res.outcome = rsgt_pkg::OUTC_CONSUMED;
            res.slot = SLOT_W'(i);
            return res;
          end
        end
        break;
      end
    end
    // same frame coming back through a consumed entry
    if (req.link_reg[0] && {req.link_reg[ADDR_W-1:1], 1'b0} == site && !tbl_pending[first] &&
        tbl_sp[first] == req.stack_ptr && site_guarded(req)) begin
      res.outcome = rsgt_pkg::OUTC_STALE;
      res.slot = SLOT_W'(first);
    end
    return res;
  endfunction

  function automatic void add_row(bit typed, logic [OUTC_W-1:0] oc, logic [SLOT_W-1:0] sl,
                                  logic op, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] sp,
                                  logic [ADDR_W-1:0] lr, logic [HW_W-1:0] prev,
                                  logic [HW_W-1:0] cur, logic prev_ok, logic cur_ok);
    dir_row_t row;
    row.req = {op, addr, sp, lr, prev, cur, prev_ok, cur_ok};
    row.typed = typed;
    row.want.outcome = oc;
    row.want.slot = sl;
    directed_rows.push_back(row);
  endfunction

  // mostly well-formed note / consume / stale requests, the rest noise
  function automatic rsgt_pkg::in_item_t random_request();
    rsgt_pkg::in_item_t r;
    int                 kind;
    int                 j;
    int                 cand[$];
    r.opcode = 1'($urandom);
    r.address = $urandom;
    r.stack_ptr = $urandom;
    r.link_reg = $urandom;
    r.prev_halfword = 16'($urandom);
    r.cur_halfword = 16'($urandom);
    r.prev_readable = 1'($urandom);
    r.cur_readable = 1'($urandom);
    kind = $urandom_range(0, 99);
    if (kind >= 78) return r;
    r.prev_halfword = rsgt_pkg::BLX_MATCH | 16'($urandom_range(0, 15) << 3);
    r.cur_halfword = rsgt_pkg::POP_MATCH | rsgt_pkg::POP_PC | 16'($urandom_range(0, 255));
    r.prev_readable = 1'b1;
    r.cur_readable = 1'b1;
    if (kind < 36) begin
      r.opcode = rsgt_pkg::OP_NOTE;
      r.address = site_pool[$urandom_range(0, SITE_POOL - 1)];
      r.address[0] = ($urandom_range(0, 19) != 0);
      r.stack_ptr = sp_pool[$urandom_range(0, SP_POOL - 1)];
    end else begin
      r.opcode = rsgt_pkg::OP_CHECK;
      // aim at a pending entry for a consume, a consumed one for a stale return
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_site[i] != '0 && tbl_pending[i] == (kind < 60)) cand.push_back(i);
      end
      if (cand.size() != 0) begin
        j = cand[$urandom_range(0, cand.size() - 1)];
        r.address = tbl_site[j];
        r.stack_ptr = tbl_sp[j];
      end else begin
        r.address = site_pool[$urandom_range(0, SITE_POOL - 1)];
        r.stack_ptr = sp_pool[$urandom_range(0, SP_POOL - 1)];
      end
      r.address[0] = 1'($urandom);
      if (kind >= 60) r.link_reg = {r.address[ADDR_W-1:1], 1'b1};
    end
    // occasionally break one part of the site
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: r.prev_readable = 1'b0;
        1: r.cur_readable = 1'b0;
        2: r.prev_halfword[$urandom_range(0, HW_W - 1)] ^= 1'b1;
        3: r.cur_halfword[$urandom_range(0, HW_W - 1)] ^= 1'b1;
        default: r.link_reg[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      endcase
    end
    return r;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // offer one request and queue its expected outcome once taken
  task automatic send_request(rsgt_pkg::in_item_t req, bit typed, rsgt_pkg::out_item_t want);
    rsgt_pkg::out_item_t predicted;
    in_item  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = guard_outcome(req);
    outcome_queue.push_back(typed ? want : predicted);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic compare_result(rsgt_pkg::out_item_t got);
    rsgt_pkg::out_item_t want;
    if (outcome_queue.size() == 0) begin
      $error("result with no request waiting: outcome %0d slot %0d", got.outcome, got.slot);
      errors++;
      return;
    end
    want = outcome_queue.pop_front();
    outcome_seen[got.outcome]++;
    if (got.outcome !== want.outcome) begin
      $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      errors++;
    end
  endtask

  // request side
  initial begin : stimulus
    int k;
    int n;
    bit burst;
    for (k = 0; k < SLOTS; k++) begin
      tbl_site[k] = '0;
      tbl_sp[k] = '0;
      tbl_pending[k] = 1'b0;
    end
    victim_ptr = 0;
    for (k = 0; k < 4; k++) outcome_seen[k] = 0;
    for (k = 0; k < SITE_POOL; k++) site_pool[k] = $urandom & ~32'd1;
    site_pool[0] = 32'd2;
    site_pool[1] = 32'hffff_fffe;
    for (k = 0; k < SP_POOL; k++) sp_pool[k] = $urandom;
    sp_pool[0] = 32'hffff_ffe0 | $urandom_range(0, 31);
    sp_pool[1] = 32'd0;

    // empty table, then every reason a note is refused
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, SITE_A | 1, SP_A, SITE_A | 1,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b0, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b0);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BX_LR, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BLX_R3, POP_NO_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, 32'd1, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, 32'd0, 32'd0, 32'd0,
            16'h0, 16'h0, 1'b0, 1'b0);
    // record, duplicate, second frame of the same site
    add_row(TYPED, rsgt_pkg::OUTC_RECORDED, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(TYPED, rsgt_pkg::OUTC_RECORDED, 3'd1, rsgt_pkg::OP_NOTE, SITE_A | 1, SP_B, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    // a check at site zero never matches
    add_row(TYPED, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, 32'd1, 32'd0, 32'd1,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    // consume, then the same frame returns: stale with odd lr, nothing with even lr
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, SITE_A, SP_A, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, SITE_A | 1, SP_A + 8,
            SITE_A | 1, BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, SITE_A | 1, SP_A + 8,
            SITE_A, BLX_R3, POP_R4_PC, 1'b1, 1'b1);
    // pending frame but pop halfword unmapped
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, SITE_A, SP_B, 0,
            BLX_R3, POP_R4_PC, 1'b1, 1'b0);
    // top of the address space: pop overflows, then an exact fit
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, ONES, 32'hffff_fff0, 0,
            BLX_R3, POP_ALL_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, ONES, 32'hffff_fff0, ONES,
            BLX_R3, POP_ALL_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, ONES, 32'hffff_ffdb, 0,
            BLX_R3, POP_ALL_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, 32'hffff_fffe,
            32'hffff_ffdb, 0, BLX_R3, POP_ALL_PC, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, ONES, ONES, ONES,
            16'hffff, 16'hffff, 1'b1, 1'b1);
    // lowest guardable site, pc as the branch register
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_NOTE, 32'd3, 32'd0, 0,
            BLX_PC, POP_PC_ONE, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, 32'd2, 32'd0, 0,
            BLX_PC, POP_PC_ONE, 1'b1, 1'b1);
    add_row(PREDICT, rsgt_pkg::OUTC_NONE, 3'd0, rsgt_pkg::OP_CHECK, 32'd3, 32'd4, 32'd3,
            BLX_PC, POP_PC_ONE, 1'b1, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
      idle_gap(pick_gap());
    end

    // random requests, with back-to-back stretches, one long output hold and two drains
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      burst = (n % 600) >= 300 && (n % 600) < 420;
      no_idle <= burst;
      if (n == 500) hold_req <= 1'b1;
      send_request(random_request(), PREDICT, '0);
      if (n == 1000 || n == 1500) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outcome_queue.size() != 0);
      end else if (!burst) begin
        idle_gap(pick_gap());
      end
    end
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (outcome_queue.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    $display("covered %0d directed and %0d random requests", directed_rows.size(),
             RANDOM_REQUESTS);
    $display("outcomes seen: %0d none, %0d recorded, %0d consumed, %0d stale", outcome_seen[0],
             outcome_seen[1], outcome_seen[2], outcome_seen[3]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check each taken result, stall at random or once on the hold request
  initial begin : result_side
    int run_left;
    int roll;
    bit held;
    run_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) compare_result(out_item);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        run_left = HOLD_CYCLES;
      end else if (run_left > 0) begin
        run_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 7);
      end else begin
        roll = $urandom_range(0, 99);
        out_stall <= (roll >= 55);
        if (roll < 55) run_left = $urandom_range(0, 5);
        else if (roll < 90) run_left = $urandom_range(0, 2);
        else run_left = $urandom_range(10, 50);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
